[design/fsfe_pkg.sv]
// Shared constants, payload types and write-port struct of the shape fill engine.
// No dependencies; every other design file uses it by scoped names.
package fsfe_pkg;

	// Frame store geometry
	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int XB    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
	localparam int YB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AB    = XB + YB;
	localparam int DEPTH = 1 << AB;
	localparam int PIX_W = 24;

	// Arithmetic widths: clip coordinates, centre offsets, squared distances
	localparam int CW  = 18;
	localparam int DW  = 12;
	localparam int SQW = 22;

	// Configuration registers
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0]  REG_CANVAS_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0]  REG_CANVAS_HEIGHT = 4'd1;
	localparam logic [CFG_DATA_W-1:0] CANVAS_RESET      = 8'd128;

	typedef enum logic [1:0] {
		ACT_FILL   = 2'd0,
		ACT_RECT   = 2'd1,
		ACT_CIRCLE = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef struct packed {
		action_t            action;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] box_width;
		logic signed [15:0] box_height;
		logic [9:0]         radius;
		logic [7:0]         paint_red;
		logic [7:0]         paint_green;
		logic [7:0]         paint_blue;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_red;
		logic [7:0] read_green;
		logic [7:0] read_blue;
		logic       in_range;
	} rsp_t;

	// Frame store write port
	typedef struct packed {
		logic             we;
		logic [AB-1:0]    addr;
		logic [PIX_W-1:0] data;
	} wr_t;

	// Sequencer status towards the top level
	typedef struct packed {
		logic cmd_ready;
		logic push;
		logic in_range;
	} stat_t;

endpackage

[design/fsfe_if.sv]
// Handshake interfaces: command, result and configuration channels.
// Depends on fsfe_pkg for payload types and widths.
interface fsfe_cmd_if;
	logic             valid;
	logic             ready;
	fsfe_pkg::cmd_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface fsfe_rsp_if;
	logic             valid;
	logic             ready;
	fsfe_pkg::rsp_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface fsfe_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [fsfe_pkg::CFG_IDX_W-1:0]      reg_index;
	logic [fsfe_pkg::CFG_DATA_W-1:0]     wr_data;
	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[design/fsfe_frame_ram.sv]
// Frame store: one write port, one registered read port, 24-bit pixels.
// Depends on fsfe_pkg for depth and the write-port struct.
module fsfe_frame_ram (
	input  logic                         clk,
	input  fsfe_pkg::wr_t                wr,
	input  logic [fsfe_pkg::AB-1:0]      rd_addr,
	output logic [fsfe_pkg::PIX_W-1:0]   rd_data
);

	logic [fsfe_pkg::PIX_W-1:0] mem [fsfe_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[design/fsfe_scan_seq.sv]
// Command sequencer: clear pass, clipping, shared squarer and the pixel scan.
// Depends on fsfe_pkg; drives the frame store write and read ports.
module fsfe_scan_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_fire,
	input  fsfe_pkg::cmd_t                cmd,
	input  logic [fsfe_pkg::XB:0]         used_w,
	input  logic [fsfe_pkg::YB:0]         used_h,
	input  logic                          rsp_free,
	output fsfe_pkg::stat_t               stat,
	output fsfe_pkg::wr_t                 wr,
	output logic [fsfe_pkg::AB-1:0]       rd_addr
);

	localparam int CW  = fsfe_pkg::CW;
	localparam int DW  = fsfe_pkg::DW;
	localparam int SQW = fsfe_pkg::SQW;
	localparam int XB  = fsfe_pkg::XB;
	localparam int YB  = fsfe_pkg::YB;
	localparam int AB  = fsfe_pkg::AB;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_SETUP = 9'b000000100,
		S_MUL_R = 9'b000001000,
		S_MUL_X = 9'b000010000,
		S_MUL_Y = 9'b000100000,
		S_SCAN  = 9'b001000000,
		S_DONE  = 9'b010000000,
		S_SPARE = 9'b100000000
	} state_t;

	state_t                state_q;
	logic [AB-1:0]         clr_q;
	fsfe_pkg::cmd_t        cmd_q;
	logic                  round_q;
	logic                  in_range_q;
	logic [XB-1:0]         xa_q, x_q;
	logic [XB:0]           xb_q;
	logic [YB-1:0]         y_q;
	logic [YB:0]           yb_q;
	logic signed [DW-1:0]  dx0_q, dx_q, dy_q;
	logic [SQW-1:0]        rsq_q, dx0sq_q, dxsq_q, dysq_q;

	// clip stage
	logic signed [CW-1:0]  px_e, py_e, bw_e, bh_e, r_e, uw_e, uh_e;
	logic signed [CW-1:0]  x0, x1, y0, y1, xa, xb, ya, yb;
	logic                  nonempty, read_in;

	// shared squarer
	logic signed [CW-1:0]    offs;
	logic signed [DW-1:0]    mop;
	logic signed [2*DW-1:0]  prod;
	logic [SQW-1:0]          sq;

	// scan
	logic [SQW:0]   dist_sq;
	logic           paint;
	logic [XB:0]    x_nx;
	logic [YB:0]    y_nx;
	logic           x_last, y_last;
	logic [SQW-1:0] dx_inc, dy_inc;

	assign px_e = {{(CW-16){cmd_q.pos_x[15]}}, cmd_q.pos_x};
	assign py_e = {{(CW-16){cmd_q.pos_y[15]}}, cmd_q.pos_y};
	assign bw_e = {{(CW-16){cmd_q.box_width[15]}}, cmd_q.box_width};
	assign bh_e = {{(CW-16){cmd_q.box_height[15]}}, cmd_q.box_height};
	assign r_e  = {{(CW-10){1'b0}}, cmd_q.radius};
	assign uw_e = {{(CW-XB-1){1'b0}}, used_w};
	assign uh_e = {{(CW-YB-1){1'b0}}, used_h};

	always_comb begin
		x0 = '0;
		x1 = '0;
		y0 = '0;
		y1 = '0;
		case (cmd_q.action)
			fsfe_pkg::ACT_FILL: begin
				x1 = uw_e;
				y1 = uh_e;
			end
			fsfe_pkg::ACT_RECT: begin
				x0 = px_e;
				y0 = py_e;
				y1 = py_e + bh_e;
				// non-positive size: collapse to an empty span
				x1 = (bw_e <= 0 || bh_e <= 0) ? px_e : px_e + bw_e;
			end
			fsfe_pkg::ACT_CIRCLE: begin
				x0 = px_e - r_e;
				x1 = px_e + r_e;
				y0 = py_e - r_e;
				y1 = py_e + r_e;
			end
			default: begin
				x0 = '0;
			end
		endcase
	end

	assign xa = (x0 < 0) ? '0 : x0;
	assign ya = (y0 < 0) ? '0 : y0;
	assign xb = (x1 > uw_e) ? uw_e : x1;
	assign yb = (y1 > uh_e) ? uh_e : y1;
	assign nonempty = (xa < xb) && (ya < yb);
	assign read_in  = (px_e >= 0) && (px_e < uw_e) && (py_e >= 0) && (py_e < uh_e);

	// squarer operand: radius, then first column offset, then first row offset
	always_comb begin
		case (state_q)
			S_MUL_R: offs = r_e;
			S_MUL_X: offs = {{(CW-XB){1'b0}}, xa_q} - px_e;
			default: offs = {{(CW-YB){1'b0}}, y_q} - py_e;
		endcase
	end
	assign mop  = offs[DW-1:0];
	assign prod = mop * mop;
	assign sq   = prod[SQW-1:0];

	assign dist_sq = {1'b0, dxsq_q} + {1'b0, dysq_q};
	assign paint   = !round_q || (dist_sq <= {1'b0, rsq_q});
	assign x_nx   = {1'b0, x_q} + 1'b1;
	assign y_nx   = {1'b0, y_q} + 1'b1;
	assign x_last = !(x_nx < xb_q);
	assign y_last = !(y_nx < yb_q);
	// (d+1)^2 - d^2 = 2d+1
	assign dx_inc = {{(SQW-DW-1){dx_q[DW-1]}}, dx_q, 1'b1};
	assign dy_inc = {{(SQW-DW-1){dy_q[DW-1]}}, dy_q, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {AB{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_fire) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					if (cmd_q.action == fsfe_pkg::ACT_READ || !nonempty) begin
						state_q <= S_DONE;
					end else if (cmd_q.action == fsfe_pkg::ACT_CIRCLE) begin
						state_q <= S_MUL_R;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_MUL_R: state_q <= S_MUL_X;
				S_MUL_X: state_q <= S_MUL_Y;
				S_MUL_Y: state_q <= S_SCAN;
				S_SCAN: begin
					if (x_last && y_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					cmd_q <= cmd;
				end
			end
			S_SETUP: begin
				round_q    <= (cmd_q.action == fsfe_pkg::ACT_CIRCLE);
				in_range_q <= (cmd_q.action == fsfe_pkg::ACT_READ) && read_in;
				xa_q       <= xa[XB-1:0];
				xb_q       <= xb[XB:0];
				yb_q       <= yb[YB:0];
				x_q        <= xa[XB-1:0];
				y_q        <= ya[YB-1:0];
			end
			S_MUL_R: rsq_q <= sq;
			S_MUL_X: begin
				dx0sq_q <= sq;
				dxsq_q  <= sq;
				dx0_q   <= mop;
				dx_q    <= mop;
			end
			S_MUL_Y: begin
				dysq_q <= sq;
				dy_q   <= mop;
			end
			S_SCAN: begin
				if (!x_last) begin
					x_q    <= x_nx[XB-1:0];
					dx_q   <= dx_q + 1'b1;
					dxsq_q <= dxsq_q + dx_inc;
				end else begin
					x_q    <= xa_q;
					dx_q   <= dx0_q;
					dxsq_q <= dx0sq_q;
					y_q    <= y_nx[YB-1:0];
					dy_q   <= dy_q + 1'b1;
					dysq_q <= dysq_q + dy_inc;
				end
			end
			default: begin
				round_q <= round_q;
			end
		endcase
	end

	always_comb begin
		wr.we   = (state_q == S_CLEAR) || ((state_q == S_SCAN) && paint);
		wr.addr = (state_q == S_CLEAR) ? clr_q : {y_q, x_q};
		wr.data = (state_q == S_CLEAR) ? '0
			: {cmd_q.paint_red, cmd_q.paint_green, cmd_q.paint_blue};
	end

	assign rd_addr = {cmd_q.pos_y[YB-1:0], cmd_q.pos_x[XB-1:0]};

	assign stat.cmd_ready = (state_q == S_IDLE);
	assign stat.push      = (state_q == S_DONE) && rsp_free;
	assign stat.in_range  = in_range_q;

	logic signed [2*DW-1:0] dxsq_chk;
	assign dxsq_chk = dx_q * dx_q;

	a_scan_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ({1'b0, x_q} < xb_q && {1'b0, y_q} < yb_q))
		else $error("scan position outside clipped box");

	a_dx_square: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && round_q) |-> (dxsq_q == dxsq_chk[SQW-1:0]))
		else $error("running column square out of step");

	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.push |=> (state_q == S_IDLE))
		else $error("sequencer not idle after result push");

endmodule

[design/framebuffer_shape_fill_engine.sv]
// Top level of the shape fill engine: channels, canvas registers, result register.
// Depends on fsfe_pkg, fsfe_if, fsfe_frame_ram and fsfe_scan_seq.
//
//  channel | dir | handshake     | carries
//  --------+-----+---------------+---------------------------------------------
//  cmd     | in  | valid/ready   | action, position, box size, radius, colour
//  rsp     | out | valid/ready   | read colour, in_range (one per request)
//  cfg     | in  | valid/ready   | reg_index, wr_data (canvas width / height)
//
// Flow: a read is answered without a scan; fill and rectangle scan the clipped area,
// circle squares radius and first offsets, then scans its clipped box (skipped when empty), one pixel
// per cycle through the single frame store write port.
// Reset: the frame store is swept to black, one pixel a cycle, over MAX_WIDTH rounded up
// to a power of two times MAX_HEIGHT rounded likewise (16384 pixels here); no request
// is taken meanwhile, configuration writes are.
// Stalls: a finished result waits in the output register; the next request is taken
// while it waits, and a second result holds the sequencer until the first leaves.
module framebuffer_shape_fill_engine (
	input  logic              clk,
	input  logic              arst_n,
	fsfe_cmd_if.sink          cmd,
	fsfe_rsp_if.source        rsp,
	fsfe_cfg_if.sink          cfg
);

	localparam int XB = fsfe_pkg::XB;
	localparam int YB = fsfe_pkg::YB;

	// canvas size registers
	logic [fsfe_pkg::CFG_DATA_W-1:0] cw_q, ch_q;
	logic [XB:0]                      used_w;
	logic [YB:0]                      used_h;

	// output register
	logic                 out_valid_q;
	fsfe_pkg::rsp_t       out_q;

	logic                 cmd_fire;
	logic                 rsp_free;
	fsfe_pkg::stat_t      stat;
	fsfe_pkg::wr_t        wr;
	logic [fsfe_pkg::AB-1:0]    rd_addr;
	logic [fsfe_pkg::PIX_W-1:0] rd_data;

	// Configuration is always accepted; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= fsfe_pkg::CANVAS_RESET;
			ch_q <= fsfe_pkg::CANVAS_RESET;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				fsfe_pkg::REG_CANVAS_WIDTH:  cw_q <= cfg.wr_data;
				fsfe_pkg::REG_CANVAS_HEIGHT: ch_q <= cfg.wr_data;
				default: begin
					cw_q <= cw_q;
				end
			endcase
		end
	end

	// Size in use saturates at the frame store size; zero leaves an empty canvas.
	assign used_w = ({10'd0, cw_q} > 18'(fsfe_pkg::MAX_WIDTH))
		? (XB+1)'(fsfe_pkg::MAX_WIDTH) : (XB+1)'(cw_q);
	assign used_h = ({10'd0, ch_q} > 18'(fsfe_pkg::MAX_HEIGHT))
		? (YB+1)'(fsfe_pkg::MAX_HEIGHT) : (YB+1)'(ch_q);

	assign cmd.ready = stat.cmd_ready;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign rsp_free  = !out_valid_q || rsp.ready;

	fsfe_scan_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_fire (cmd_fire),
		.cmd      (cmd.payload),
		.used_w   (used_w),
		.used_h   (used_h),
		.rsp_free (rsp_free),
		.stat     (stat),
		.wr       (wr),
		.rd_addr  (rd_addr)
	);

	fsfe_frame_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result register: draws and off-canvas reads report black with in_range low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.push) begin
			out_q.read_red   <= stat.in_range ? rd_data[23:16] : 8'd0;
			out_q.read_green <= stat.in_range ? rd_data[15:8]  : 8'd0;
			out_q.read_blue  <= stat.in_range ? rd_data[7:0]   : 8'd0;
			out_q.in_range   <= stat.in_range;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> !cmd.ready)
		else $error("request taken while previous one in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.push |-> rsp_free)
		else $error("result register overwritten");

	a_off_canvas_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.in_range) |->
			(out_q.read_red == 8'd0 && out_q.read_green == 8'd0 && out_q.read_blue == 8'd0))
		else $error("non-zero colour without in_range");

endmodule

[tb/sv/framebuffer_shape_fill_engine_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the shape fill engine: drives draw and read requests, mirrors
// the frame store and canvas registers, and checks every response in order.
// Depends on fsfe_pkg, fsfe_if and the framebuffer_shape_fill_engine top level.
module framebuffer_shape_fill_engine_test;
	import fsfe_pkg::*;

	// Longest quiet stretch is a whole-canvas fill (or the reset sweep) plus a receiver
	// hold-off; allow several times that before calling it a hang.
	localparam int QUIET_LIMIT   = 80000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 42;

	logic clk;
	logic arst_n;

	fsfe_cmd_if cmd_ch ();
	fsfe_rsp_if rsp_ch ();
	fsfe_cfg_if cfg_ch ();

	framebuffer_shape_fill_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Mirror of the block: pixel store and the two canvas registers
	logic [PIX_W-1:0] shadow_fb [DEPTH];
	logic [7:0]       shadow_w;
	logic [7:0]       shadow_h;

	// Responses still owed by the block, oldest first
	rsp_t pending_rsp [$];

	int err_count;
	int quiet_cycles;

	// Sender burst control and receiver stall pattern
	bit gaps_on;
	int burst_left;
	int rx_mode;
	bit hold_req;

	// Last draw position, so that reads land on freshly painted pixels
	int last_x;
	int last_y;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int used_width();
		return (int'(shadow_w) > MAX_WIDTH) ? MAX_WIDTH : int'(shadow_w);
	endfunction

	function automatic int used_height();
		return (int'(shadow_h) > MAX_HEIGHT) ? MAX_HEIGHT : int'(shadow_h);
	endfunction

	function automatic logic signed [15:0] s16(input int v);
		return v[15:0];
	endfunction

	function automatic logic [9:0] r10(input int v);
		return v[9:0];
	endfunction

	// Work out what one accepted request does to the store and what it answers
	task automatic paint_and_answer(input cmd_t c);
		rsp_t r;
		int uw, uh, px, py, bw, bh, rad;
		int x0, x1, y0, y1, xa, xb, ya, yb, x, y;
		bit round;
		bit draws;
		logic [PIX_W-1:0] col;
		logic [PIX_W-1:0] pix;
		r = '0;
		uw = used_width();
		uh = used_height();
		px = c.pos_x;
		py = c.pos_y;
		bw = c.box_width;
		bh = c.box_height;
		rad = int'(c.radius);
		col = {c.paint_red, c.paint_green, c.paint_blue};
		round = 1'b0;
		draws = 1'b0;
		x0 = 0; x1 = 0; y0 = 0; y1 = 0;
		case (c.action)
			ACT_FILL: begin
				x1 = uw; y1 = uh; draws = 1'b1;
			end
			ACT_RECT: begin
				// zero or negative extent paints nothing
				if (bw > 0 && bh > 0) begin
					x0 = px; x1 = px + bw; y0 = py; y1 = py + bh; draws = 1'b1;
				end
			end
			ACT_CIRCLE: begin
				// half-open scan box; radius zero leaves it empty
				x0 = px - rad; x1 = px + rad; y0 = py - rad; y1 = py + rad;
				round = 1'b1; draws = 1'b1;
			end
			default: begin
				// off-canvas reads answer all zero
				if (px >= 0 && px < uw && py >= 0 && py < uh) begin
					pix = shadow_fb[py * MAX_WIDTH + px];
					r.read_red   = pix[23:16];
					r.read_green = pix[15:8];
					r.read_blue  = pix[7:0];
					r.in_range   = 1'b1;
				end
			end
		endcase
		if (draws) begin
			xa = (x0 < 0) ? 0 : x0;
			xb = (x1 > uw) ? uw : x1;
			ya = (y0 < 0) ? 0 : y0;
			yb = (y1 > uh) ? uh : y1;
			for (y = ya; y < yb; y++)
				for (x = xa; x < xb; x++)
					if (!round || (x - px) * (x - px) + (y - py) * (y - py) <= rad * rad)
						shadow_fb[y * MAX_WIDTH + x] = col;
		end
		pending_rsp = {pending_rsp, r};
	endtask

	// Sampling at the rising edge sees values from before this edge's updates
	always @(posedge clk) begin
		rsp_t got, exp_rsp;
		bit moved;
		moved = 1'b0;
		if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
			moved = 1'b1;
			case (cfg_ch.reg_index)
				REG_CANVAS_WIDTH:  shadow_w = cfg_ch.wr_data;
				REG_CANVAS_HEIGHT: shadow_h = cfg_ch.wr_data;
				default: ;
			endcase
		end
		if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
			moved = 1'b1;
			paint_and_answer(cmd_ch.payload);
		end
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			moved = 1'b1;
			got = rsp_ch.payload;
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with none outstanding: actual %h", $time, got);
				err_count++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (got.read_red !== exp_rsp.read_red) begin
					$display("%0t: read_red expected %h actual %h", $time,
						exp_rsp.read_red, got.read_red);
					err_count++;
				end
				if (got.read_green !== exp_rsp.read_green) begin
					$display("%0t: read_green expected %h actual %h", $time,
						exp_rsp.read_green, got.read_green);
					err_count++;
				end
				if (got.read_blue !== exp_rsp.read_blue) begin
					$display("%0t: read_blue expected %h actual %h", $time,
						exp_rsp.read_blue, got.read_blue);
					err_count++;
				end
				if (got.in_range !== exp_rsp.in_range) begin
					$display("%0t: in_range expected %b actual %b", $time,
						exp_rsp.in_range, got.in_range);
					err_count++;
				end
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	// Hang guard
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("FAIL framebuffer_shape_fill_engine");
		$finish;
	end

	// Receiver: stall pattern per phase; a hold-off request parks ready low for a
	// long stretch counted here, so results pile up and the input backs off
	initial begin
		int rx_tick;
		rx_tick = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rx_tick++;
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				case (rx_mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					2: rsp_ch.ready <= ((rx_tick % 11) < 6);
					default: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
				endcase
			end
		end
	end

	// One request; valid stays up for a following request unless a gap is due
	task automatic send_request(input cmd_t c);
		cmd_ch.payload <= c;
		cmd_ch.valid   <= 1'b1;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		if (gaps_on) begin
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				cmd_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	// Sender goes quiet until every response is in, then lets the block settle
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Canvas width then height, back to back on the write channel
	task automatic write_canvas(input logic [7:0] w, input logic [7:0] h);
		cfg_ch.reg_index <= REG_CANVAS_WIDTH;
		cfg_ch.wr_data   <= w;
		cfg_ch.valid     <= 1'b1;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.reg_index <= REG_CANVAS_HEIGHT;
		cfg_ch.wr_data   <= h;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic cmd_t make_cmd(input action_t a, input int x, input int y,
			input int bw, input int bh, input int r, input logic [23:0] col);
		cmd_t c;
		c.action      = a;
		c.pos_x       = s16(x);
		c.pos_y       = s16(y);
		c.box_width   = s16(bw);
		c.box_height  = s16(bh);
		c.radius      = r10(r);
		c.paint_red   = col[23:16];
		c.paint_green = col[15:8];
		c.paint_blue  = col[7:0];
		return c;
	endfunction

	task automatic read_pixel(input int x, input int y);
		send_request(make_cmd(ACT_READ, x, y, 0, 0, 0, 24'h0));
	endtask

	// Random request: every field starts fully random, then most get pulled onto
	// the canvas so that draws and reads meet
	function automatic cmd_t random_cmd(input bit big);
		cmd_t c;
		logic [31:0] rv;
		int sw, sh, sel, t;
		sw = (used_width() < 1) ? 4 : used_width();
		sh = (used_height() < 1) ? 4 : used_height();
		rv = $urandom; c.pos_x = rv[15:0]; c.pos_y = rv[31:16];
		rv = $urandom; c.box_width = rv[15:0]; c.box_height = rv[31:16];
		rv = $urandom; c.radius = rv[9:0]; c.paint_red = rv[17:10]; c.paint_green = rv[25:18];
		rv = $urandom; c.paint_blue = rv[7:0];
		sel = $urandom_range(0, 99);
		if (sel < (big ? 2 : 8))
			c.action = ACT_FILL;
		else if (sel < 35)
			c.action = ACT_RECT;
		else if (sel < 60)
			c.action = ACT_CIRCLE;
		else
			c.action = ACT_READ;
		if ($urandom_range(0, 9) != 0) begin
			if (c.action == ACT_READ && $urandom_range(0, 1) == 1) begin
				t = $urandom_range(0, 6); c.pos_x = s16(last_x + t - 3);
				t = $urandom_range(0, 6); c.pos_y = s16(last_y + t - 3);
			end else begin
				t = $urandom_range(0, sw + 3); c.pos_x = s16(t - 2);
				t = $urandom_range(0, sh + 3); c.pos_y = s16(t - 2);
			end
		end
		sel = $urandom_range(0, 9);
		if (sel > 1 || (big && sel == 1)) begin
			c.box_width  = s16($urandom_range(1, (big ? 16 : sw / 2) + 3));
			c.box_height = s16($urandom_range(1, (big ? 16 : sh / 2) + 3));
		end else if (sel == 1) begin
			t = $urandom_range(0, 3); c.box_width = s16(-t);
			t = $urandom_range(0, 3); c.box_height = s16(($urandom_range(0, 1) == 1) ? -t : t);
		end
		if ($urandom_range(0, big ? 19 : 9) != 0)
			c.radius = r10($urandom_range(0, big ? 12 : (sw > sh ? sw : sh) / 2 + 2));
		return c;
	endfunction

	// Power-on contents: black everywhere, default canvas edges
	task automatic test_reset_state();
		read_pixel(0, 0);
		read_pixel(MAX_WIDTH - 1, MAX_HEIGHT - 1);
		read_pixel(MAX_WIDTH, 0);
		read_pixel(0, MAX_HEIGHT);
		read_pixel(-1, 5);
		read_pixel(-32768, 32767);
		wait_drained();
	endtask

	// Each action at the default canvas, the clipping edges and the degenerate shapes
	task automatic test_directed_shapes();
		send_request(make_cmd(ACT_FILL, 0, 0, 0, 0, 0, 24'h123456));
		read_pixel(0, 0);
		read_pixel(127, 127);
		send_request(make_cmd(ACT_RECT, 10, 20, 5, 3, 0, 24'hFF0000));
		read_pixel(10, 20);
		read_pixel(14, 22);
		read_pixel(15, 22);
		read_pixel(14, 23);
		// zero width, negative height: nothing painted
		send_request(make_cmd(ACT_RECT, 30, 30, 0, 5, 0, 24'h00FF00));
		send_request(make_cmd(ACT_RECT, 30, 30, 5, -1, 0, 24'h00FF00));
		read_pixel(30, 30);
		// corner just off the left edge, extent runs past the bottom right
		send_request(make_cmd(ACT_RECT, -5, 120, 32767, 32767, 0, 24'h00FF00));
		read_pixel(0, 127);
		send_request(make_cmd(ACT_RECT, -32768, -32768, 32767, 32767, 0, 24'hFFFFFF));
		// radius zero paints nothing
		send_request(make_cmd(ACT_CIRCLE, 50, 50, 0, 0, 0, 24'hABCDEF));
		read_pixel(50, 50);
		send_request(make_cmd(ACT_CIRCLE, 60, 60, 0, 0, 5, 24'h00FFFF));
		read_pixel(60, 60);
		read_pixel(65, 60);
		read_pixel(55, 60);
		read_pixel(64, 64);
		send_request(make_cmd(ACT_CIRCLE, 32767, -32768, 0, 0, 1023, 24'h000000));
		send_request(make_cmd(ACT_CIRCLE, 64, 64, 0, 0, 1023, 24'hFFFFFF));
		read_pixel(127, 0);
		read_pixel(32767, 0);
		wait_drained();
	endtask

	// Empty canvas, saturating registers, and pixels kept while off the canvas
	task automatic test_canvas_extremes();
		write_canvas(8'd8, 8'd8);
		send_request(make_cmd(ACT_FILL, 0, 0, 0, 0, 0, 24'hA0A0A0));
		wait_drained();
		write_canvas(8'd4, 8'd4);
		send_request(make_cmd(ACT_FILL, 0, 0, 0, 0, 0, 24'h0B0B0B));
		send_request(make_cmd(ACT_RECT, 2, 2, 10, 10, 0, 24'hC0FFEE));
		read_pixel(5, 5);
		read_pixel(3, 3);
		wait_drained();
		// re-enlarged canvas shows what was painted before the shrink
		write_canvas(8'd8, 8'd8);
		read_pixel(5, 5);
		read_pixel(2, 2);
		wait_drained();
		write_canvas(8'd0, 8'd0);
		send_request(make_cmd(ACT_FILL, 0, 0, 0, 0, 0, 24'hFFFFFF));
		send_request(make_cmd(ACT_RECT, 0, 0, 4, 4, 0, 24'hFFFFFF));
		send_request(make_cmd(ACT_CIRCLE, 2, 2, 0, 0, 3, 24'hFFFFFF));
		read_pixel(0, 0);
		wait_drained();
		write_canvas(8'd255, 8'd1);
		send_request(make_cmd(ACT_RECT, -3, -3, 200, 10, 0, 24'h5A5A5A));
		read_pixel(127, 0);
		read_pixel(128, 0);
		read_pixel(0, 1);
		wait_drained();
		write_canvas(8'd1, 8'd255);
		send_request(make_cmd(ACT_CIRCLE, 0, 64, 0, 0, 70, 24'h00FF00));
		read_pixel(0, 127);
		read_pixel(1, 64);
		wait_drained();
	endtask

	// Receiver holds off while the sender keeps offering: output register fills,
	// sequencer holds, input stalls
	task automatic test_backpressure();
		int i;
		write_canvas(8'd6, 8'd6);
		rx_mode = 0;
		gaps_on = 1'b0;
		hold_req = 1'b1;
		for (i = 0; i < 10; i++)
			if (i % 2 == 0)
				send_request(make_cmd(ACT_RECT, i % 6, 1, 2, 2, 0, {8'(i), 8'hFF, 8'h00}));
			else
				read_pixel(i % 6, 1);
		wait_drained();
	endtask

	// Phases of random traffic, each on a canvas of its own
	task automatic test_random_traffic();
		cmd_t c;
		int ph, i;
		logic [7:0] w, h;
		bit big;
		for (ph = 0; ph < PHASES; ph++) begin
			w = 8'($urandom_range(1, 24));
			h = 8'($urandom_range(1, 24));
			case (ph)
				3:  w = 8'd0;
				5:  begin w = 8'd255; h = 8'($urandom_range(1, 6)); end
				7:  begin w = 8'd128; h = 8'd128; end
				9:  begin w = 8'd1; h = 8'd1; end
				10: h = 8'd255;
				default: ;
			endcase
			write_canvas(w, h);
			big = (used_width() * used_height() > 2000);
			rx_mode = ph % 4;
			gaps_on = (ph % 3 != 2);
			burst_left = $urandom_range(1, 12);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				c = random_cmd(big);
				if (c.action != ACT_READ) begin
					last_x = c.pos_x;
					last_y = c.pos_y;
				end
				send_request(c);
			end
			wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = '0;
		cfg_ch.wr_data = '0;
		foreach (shadow_fb[k])
			shadow_fb[k] = '0;
		shadow_w = CANVAS_RESET;
		shadow_h = CANVAS_RESET;
		err_count = 0;
		quiet_cycles = 0;
		gaps_on = 1'b1;
		burst_left = 4;
		rx_mode = 1;
		hold_req = 1'b0;
		last_x = 0;
		last_y = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first requests wait out the store clearing sweep
		test_reset_state();
		test_directed_shapes();
		test_canvas_extremes();
		test_backpressure();
		test_random_traffic();

		wait_drained();
		if (err_count == 0)
			$display("PASS framebuffer_shape_fill_engine");
		else
			$display("FAIL framebuffer_shape_fill_engine");
		$finish;
	end

endmodule

[files.f]
design/fsfe_pkg.sv
design/fsfe_if.sv
design/fsfe_frame_ram.sv
design/fsfe_scan_seq.sv
design/framebuffer_shape_fill_engine.sv
tb/sv/framebuffer_shape_fill_engine_test.sv
